@@ sv/lru_victim_select_pkg.sv @@
package lru_pkg;

    // Frames that the pinned mask and the frame index can name
    localparam int MASK_FRAMES = 16;
    localparam int FRAME_COUNT_DEFAULT = 16;

    localparam int FRAME_W = 4;
    localparam int TIME_W = 32;

    // Input tdata layout, lowest bits first
    localparam int FRAME_LSB = 0;
    localparam int TIME_LSB = FRAME_LSB + FRAME_W;
    localparam int MASK_LSB = TIME_LSB + TIME_W;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 8;

    typedef enum logic
    {
        CMD_PIN = 1'b0,
        CMD_VICTIM = 1'b1
    } cmd_t;

    typedef enum logic
    {
        STATUS_FOUND = 1'b0,
        STATUS_NO_FREE = 1'b1
    } status_t;

endpackage

@@ sv/lru_victim_select.sv @@
// LRU victim selection over per-frame last-use times.
//
// Input stream s_axis: tuser[0] is the command (pin or victim request).
// A pin item writes use_time for frame_sel and gives no result; a pin of
// a frame beyond the store is dropped. A victim item carries pinned_mask and
// gives exactly one result item on m_axis: the unpinned frame with the
// oldest time (lowest index on a tie) and status 0, or index 0 and status 1
// when every frame is pinned. The chosen frame's time is cleared to zero.
//
// Timing: a pin is written to the store as it is accepted. A victim request
// reads the time store one entry per cycle through its single read port, all
// min(FRAME_COUNT,16) entries in turn, and the next item is taken only once
// its result is loaded into the output register. Only one item is in work at a time.
// The result sits in an output register: while the receiver stalls, the
// block holds it and keeps taking pin items, but a finished victim request
// waits until the register is free before it writes back.
// Reset marks every entry as never written, which reads as time zero, so no
// clearing pass is needed.
module lru_victim_select
    import lru_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] frame_sel, [35:4] use_time, [51:36] pinned_mask, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] victim_index, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] status
    output logic [0:0]            m_axis_tuser
);

    localparam int DEPTH = (FRAME_COUNT < MASK_FRAMES) ? FRAME_COUNT : MASK_FRAMES;
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [TIME_W-1:0] time_mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;

    logic [TIME_W-1:0] rd_data_reg;
    logic              rd_written_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic              rd_busy_reg;
    logic              cmp_valid_reg;
    logic              cmp_last_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;

    logic [DEPTH-1:0]  mask_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_time_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    status_t           out_status_reg;

    logic              in_fire;
    logic              pin_write;
    logic              out_free;
    logic              rd_last;
    logic [TIME_W-1:0] cand_time;
    logic              cand_take;
    logic [FRAME_W-1:0] in_frame;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              wr_en;

    assign in_frame = s_axis_tdata[FRAME_LSB +: FRAME_W];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign pin_write = in_fire && (cmd_t'(s_axis_tuser[0]) == CMD_PIN)
        && ({1'b0, in_frame} < (FRAME_W + 1)'(DEPTH));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_last = (rd_addr_reg == IDX_W'(DEPTH - 1));

    // Never-written entries read as time zero
    assign cand_time = rd_written_reg ? rd_data_reg : '0;
    assign cand_take = cmp_valid_reg && !mask_reg[cmp_idx_reg]
        && (!found_reg || (cand_time < best_time_reg));

    // One write port: pin in idle, clear of the victim at finish
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = best_idx_reg;
        wr_data = '0;
        if (pin_write)
        begin
            wr_en = 1'b1;
            wr_addr = in_frame[IDX_W-1:0];
            wr_data = s_axis_tdata[TIME_LSB +: TIME_W];
        end
        else if ((state_reg == ST_FINISH) && out_free && found_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= time_mem[rd_addr_reg];
        rd_written_reg <= written_reg[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mask_reg <= s_axis_tdata[MASK_LSB +: DEPTH];
        end
        if (state_reg == ST_SCAN)
        begin
            cmp_idx_reg <= rd_addr_reg;
            cmp_last_reg <= rd_last;
            if (cand_take)
            begin
                best_idx_reg <= cmp_idx_reg;
                best_time_reg <= cand_time;
            end
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_idx_reg <= found_reg ? best_idx_reg : '0;
            out_status_reg <= found_reg ? STATUS_FOUND : STATUS_NO_FREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_addr_reg <= '0;
            rd_busy_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (cmd_t'(s_axis_tuser[0]) == CMD_VICTIM))
                    begin
                        state_reg <= ST_SCAN;
                        rd_addr_reg <= '0;
                        rd_busy_reg <= 1'b1;
                        found_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    // read port is idle by the last compare, so this drops valid there
                    cmp_valid_reg <= rd_busy_reg;
                    if (rd_busy_reg)
                    begin
                        rd_busy_reg <= !rd_last;
                        if (!rd_last)
                        begin
                            rd_addr_reg <= rd_addr_reg + 1'b1;
                        end
                    end
                    if (cand_take)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (cmp_valid_reg && cmp_last_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {(OUT_DATA_W - FRAME_W)'(0), FRAME_W'(out_idx_reg)};
    assign m_axis_tuser = out_status_reg;

    property p_victim_unpinned;
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && found_reg) |-> !mask_reg[best_idx_reg];
    endproperty
    a_victim_unpinned: assert property (p_victim_unpinned)
        else $error("victim frame is pinned");

    property p_no_free_index_zero;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == STATUS_NO_FREE))
            |-> (m_axis_tdata == '0);
    endproperty
    a_no_free_index_zero: assert property (p_no_free_index_zero)
        else $error("no-free result carries a nonzero index");

    property p_finish_loads_output;
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=> (m_axis_tvalid && s_axis_tready);
    endproperty
    a_finish_loads_output: assert property (p_finish_loads_output)
        else $error("finished request did not reach the output");

    property p_last_compare_ends_scan;
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && cmp_valid_reg && cmp_last_reg)
            |=> (state_reg == ST_FINISH);
    endproperty
    a_last_compare_ends_scan: assert property (p_last_compare_ends_scan)
        else $error("scan did not end after the last entry");

    property p_output_held_not_overwritten;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata);
    endproperty
    a_output_held_not_overwritten: assert property (p_output_held_not_overwritten)
        else $error("pending result overwritten");

endmodule

@@ tb/tb.sv @@
module tb
    import lru_pkg::*;
();

    typedef struct packed {
        cmd_t                   cmd;
        logic [FRAME_W-1:0]     frame;
        logic [TIME_W-1:0]      stamp;
        logic [MASK_FRAMES-1:0] pin_mask;
    } frame_cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] index;
        status_t            status;
    } victim_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire [OUT_DATA_W-1:0]  m_axis_tdata;
    wire [0:0]             m_axis_tuser;

    frame_cmd_t        cmd_q[$];
    victim_t           victim_q[$];
    logic [TIME_W-1:0] lru_time [MASK_FRAMES];

    frame_cmd_t in_flight;
    frame_cmd_t nxt;
    int send_wait;
    int send_burst;
    int send_next;
    int recv_wait;
    int recv_burst;
    int recv_next;
    int errors;
    int pins_taken;
    int victims_taken;
    int victims_seen;
    int no_free_seen;

    lru_victim_select #(
        .FRAME_COUNT(16)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", victim_q.size());
        $display("lru_victim_select verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // Mostly a random wait, with occasional runs of back-to-back items
    task automatic draw_wait(inout int burst, output int w);
        if (burst > 0)
        begin
            burst--;
            w = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(8, 40);
            w = 0;
        end
        else
            w = $urandom_range(0, 11);
    endtask

    task automatic queue_cmd(input frame_cmd_t c);
        cmd_q = {cmd_q, c};
    endtask

    function automatic frame_cmd_t pin_cmd(input logic [FRAME_W-1:0] frame,
                                           input logic [TIME_W-1:0] stamp);
        frame_cmd_t c;
        c.cmd = CMD_PIN;
        c.frame = frame;
        c.stamp = stamp;
        c.pin_mask = MASK_FRAMES'($urandom);
        return c;
    endfunction

    function automatic frame_cmd_t victim_cmd(input logic [MASK_FRAMES-1:0] pin_mask);
        frame_cmd_t c;
        c.cmd = CMD_VICTIM;
        c.frame = FRAME_W'($urandom);
        c.stamp = $urandom;
        c.pin_mask = pin_mask;
        return c;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_cmd(input frame_cmd_t c);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[FRAME_LSB +: FRAME_W] = c.frame;
        d[TIME_LSB +: TIME_W] = c.stamp;
        d[MASK_LSB +: MASK_FRAMES] = c.pin_mask;
        return d;
    endfunction

    // Update the time store and queue the victim the block must return
    function automatic void apply_command(input frame_cmd_t c);
        int best;
        logic [TIME_W-1:0] best_t;
        victim_t v;
        if (c.cmd == CMD_PIN)
            lru_time[c.frame] = c.stamp;
        else
        begin
            best = -1;
            best_t = '0;
            for (int i = 0; i < MASK_FRAMES; i++)
                if (!c.pin_mask[i] && (best < 0 || lru_time[i] < best_t))
                begin
                    best = i;
                    best_t = lru_time[i];
                end
            if (best < 0)
            begin
                v.index = '0;
                v.status = STATUS_NO_FREE;
            end
            else
            begin
                lru_time[best] = '0;
                v.index = best[FRAME_W-1:0];
                v.status = STATUS_FOUND;
            end
            victim_q = {victim_q, v};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_command(in_flight);
                if (in_flight.cmd == CMD_PIN)
                    pins_taken++;
                else
                    victims_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait <= send_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    nxt = cmd_q.pop_front();
                    in_flight <= nxt;
                    s_axis_tdata <= pack_cmd(nxt);
                    s_axis_tuser <= nxt.cmd;
                    s_axis_tvalid <= 1'b1;
                    draw_wait(send_burst, send_next);
                    send_wait <= send_next;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall countdown runs only while a result is offered
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (victim_q.size() == 0)
                report_mismatch("result item with no victim request waiting");
            else
            begin
                victim_t want;
                want = victim_q.pop_front();
                if (want.status == STATUS_FOUND)
                    victims_seen++;
                else
                    no_free_seen++;
                if (m_axis_tdata[FRAME_W-1:0] !== want.index)
                    report_mismatch($sformatf("victim_index %0d, expected %0d",
                                              m_axis_tdata[FRAME_W-1:0], want.index));
                if (m_axis_tuser[0] !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              m_axis_tuser[0], want.status));
                if (m_axis_tdata[OUT_DATA_W-1:FRAME_W] !== '0)
                    report_mismatch($sformatf("tdata padding %h not zero",
                                              m_axis_tdata[OUT_DATA_W-1:FRAME_W]));
            end
            draw_wait(recv_burst, recv_next);
            recv_wait <= recv_next;
            m_axis_tready <= (recv_next == 0);
        end
        else if (m_axis_tvalid && recv_wait > 0)
        begin
            recv_wait <= recv_wait - 1;
            m_axis_tready <= (recv_wait == 1);
        end
        else if (recv_wait == 0)
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        int n;
        int k;
        int r;
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] stamp;
        logic [MASK_FRAMES-1:0] pin_mask;

        errors = 0;
        pins_taken = 0;
        victims_taken = 0;
        victims_seen = 0;
        no_free_seen = 0;
        send_burst = 0;
        recv_burst = 0;
        foreach (lru_time[i])
            lru_time[i] = '0;

        // All times zero after reset: ties go to the lowest free index
        queue_cmd(victim_cmd(16'h0000));
        queue_cmd(victim_cmd(16'hFFFF));
        queue_cmd(victim_cmd(16'h8000));
        queue_cmd(victim_cmd(16'hBFFF));
        queue_cmd(pin_cmd(4'd0, 32'hFFFF_FFFF));
        queue_cmd(pin_cmd(4'd15, 32'h0000_0001));
        queue_cmd(victim_cmd(16'h7FFE));
        queue_cmd(victim_cmd(16'h7FFE));
        queue_cmd(pin_cmd(4'd15, 32'hFFFF_FFFF));
        queue_cmd(victim_cmd(16'h7FFE));
        queue_cmd(victim_cmd(16'hFFFE));
        queue_cmd(pin_cmd(4'd7, 32'hAAAA_AAAA));
        queue_cmd(pin_cmd(4'd8, 32'h5555_5555));
        queue_cmd(victim_cmd(16'hFE7F));
        queue_cmd(victim_cmd(16'hFE7F));
        queue_cmd(victim_cmd(16'hFFFF));
        queue_cmd(pin_cmd(4'd3, 32'h0000_0000));
        queue_cmd(victim_cmd(16'h7FFF));
        queue_cmd(victim_cmd(16'hFFFF));

        // Runs of pins followed by a victim request
        clock_now = 32'h0000_0100;
        n = 0;
        while (n < 1100)
        begin
            k = $urandom_range(0, 5);
            repeat (k)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    clock_now = clock_now + $urandom_range(1, 5);
                    stamp = clock_now;
                end
                else if (r < 8)
                    stamp = $urandom;
                else
                    stamp = $urandom_range(0, 3);
                queue_cmd(pin_cmd(FRAME_W'($urandom), stamp));
                n++;
            end
            case ($urandom_range(0, 7))
                0: pin_mask = '0;
                1: pin_mask = '1;
                2: pin_mask = ~(16'h0001 << $urandom_range(0, 15));
                3: pin_mask = MASK_FRAMES'($urandom & $urandom);
                4: pin_mask = MASK_FRAMES'($urandom | $urandom);
                default: pin_mask = MASK_FRAMES'($urandom);
            endcase
            queue_cmd(victim_cmd(pin_mask));
            n++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (cmd_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (victim_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d pin items and %0d victim requests", pins_taken, victims_taken);
        $display("checked %0d chosen victims and %0d all-pinned results",
                 victims_seen, no_free_seen);
        if (errors == 0)
            $display("lru_victim_select verification clean");
        else
            $display("lru_victim_select verification failed");
        $finish;
    end

endmodule
